@@ hdl/rcit_pkg.sv @@
// Package for the reference-counted identifier table.
// Holds the operation codes and the item type passed from the front to the table.
package rcit_pkg;

   localparam int IdW    = 32;
   localparam int CountW = 16;
   localparam int OpW    = 2;

   localparam logic [CountW-1:0] CountMax = '1;

   typedef enum logic [OpW-1:0] {
      OP_ADD     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_QUERY   = 2'd2,
      OP_RETIRE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [IdW-1:0]   id;
      logic             id_zero;
   } item_type;

endpackage

@@ hdl/rcit_front.sv @@
// Front end of the identifier table: accepts request beats, classifies them
// and holds them in a two-entry queue for the table unit. Uses rcit_pkg.
module rcit_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_operation,
   input  logic [31:0]            req_item_id,
   output logic                   q_valid,
   output rcit_pkg::item_type     q_item,
   input  logic                   q_pop
);
   import rcit_pkg::*;

   item_type    slot0_ff, slot1_ff;
   logic [1:0]  fill_ff;
   logic [1:0]  fill_in;
   item_type    new_item;
   logic        push;

   // Classify the incoming beat
   always_comb begin
      new_item.op      = op_type'(req_operation);
      new_item.id      = req_item_id;
      new_item.id_zero = (req_item_id == '0);
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = slot0_ff;

   // Track queue fill
   always_comb begin
      fill_in = fill_ff;
      if (push && !q_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Shift the queue slots; head is slot0
   always_ff @(posedge clock) begin
      if (push && q_pop) begin
         if (fill_ff == 2'd1) begin
            slot0_ff <= new_item;
         end else begin
            slot0_ff <= slot1_ff;
            slot1_ff <= new_item;
         end
      end else if (push) begin
         if (fill_ff == 2'd0) begin
            slot0_ff <= new_item;
         end else begin
            slot1_ff <= new_item;
         end
      end else if (q_pop) begin
         slot0_ff <= slot1_ff;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'd2) else $error("queue fill out of range");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> fill_ff == $past(fill_ff) + 2'd1)
      else $error("queue fill did not advance on push");

endmodule

@@ hdl/rcit_back.sv @@
// Table unit of the identifier table: ordered entries with reference counts,
// parallel lookup then update, and the result register. Uses rcit_pkg.
module rcit_back #(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  rcit_pkg::item_type     q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit,
   output logic [15:0]            rsp_ref_count,
   output logic [4:0]             rsp_entry_count,
   output logic                   rsp_evicted_oldest
);
   import rcit_pkg::*;

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OccW = $clog2(DEPTH + 1);
   localparam logic [OccW-1:0] OccFull = OccW'(DEPTH);
   localparam logic [IdxW-1:0] IdxLast = IdxW'(DEPTH - 1);

   typedef enum logic {S_LOOKUP, S_EXEC} state_type;

   // Table storage, no reset: entries at and above the fill are never read
   logic [IdW-1:0]    id_ff  [DEPTH];
   logic [CountW-1:0] cnt_ff [DEPTH];
   logic [IdW-1:0]    id_in  [DEPTH];
   logic [CountW-1:0] cnt_in [DEPTH];
   logic [OccW-1:0]   occ_ff, occ_in;

   state_type         state_ff;
   item_type          item_ff;
   logic [DEPTH-1:0]  match_ff, match_in;

   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [CountW-1:0] rsp_cnt_ff;
   logic [4:0]        rsp_occ_ff;
   logic              rsp_evict_ff;

   logic              hit;
   logic [IdxW-1:0]   pos;
   logic [CountW-1:0] cur_cnt;
   logic              out_free, do_exec;

   logic              remove_en, append_en, update_en;
   logic [IdxW-1:0]   remove_pos, append_idx;
   logic [CountW-1:0] update_val, res_cnt;
   logic              res_evict;
   logic [OccW+4:0]   occ_wide;

   assign q_pop    = (state_ff == S_LOOKUP) && q_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign do_exec  = (state_ff == S_EXEC) && out_free;

   // Compare the queue head against every occupied entry
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (id_ff[i] == q_item.id) && (OccW'(i) < occ_ff) && !q_item.id_zero;
      end
   end

   // Encode the matching entry and pick its count
   always_comb begin
      hit     = |match_ff;
      pos     = '0;
      cur_cnt = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pos     = pos | (match_ff[i] ? IdxW'(i) : '0);
         cur_cnt = cur_cnt | (match_ff[i] ? cnt_ff[i] : '0);
      end
   end

   // Decide the table action for the held item
   always_comb begin
      remove_en  = 1'b0;
      remove_pos = pos;
      append_en  = 1'b0;
      append_idx = occ_ff[IdxW-1:0];
      update_en  = 1'b0;
      update_val = cur_cnt;
      res_cnt    = '0;
      res_evict  = 1'b0;
      occ_in     = occ_ff;
      if (!item_ff.id_zero) begin
         unique case (item_ff.op)
            OP_ADD: begin
               if (hit) begin
                  update_en  = 1'b1;
                  update_val = (cur_cnt == CountMax) ? cur_cnt : cur_cnt + 1'b1;
                  res_cnt    = update_val;
               end else begin
                  append_en = 1'b1;
                  res_cnt   = CountW'(1);
                  if (occ_ff >= OccFull) begin
                     remove_en  = 1'b1;
                     remove_pos = '0;
                     append_idx = IdxLast;
                     res_evict  = 1'b1;
                     occ_in     = OccFull;
                  end else begin
                     occ_in = occ_ff + 1'b1;
                  end
               end
            end
            OP_RELEASE: begin
               if (hit) begin
                  update_val = (cur_cnt == '0) ? '0 : cur_cnt - 1'b1;
                  res_cnt    = update_val;
                  if (update_val == '0) begin
                     remove_en = 1'b1;
                     occ_in    = occ_ff - 1'b1;
                  end else begin
                     update_en = 1'b1;
                  end
               end
            end
            OP_QUERY: begin
               if (hit) begin
                  res_cnt = cur_cnt;
               end
            end
            OP_RETIRE: begin
               if (hit) begin
                  remove_en = 1'b1;
                  occ_in    = occ_ff - 1'b1;
               end
            end
            default: begin
               res_cnt = '0;
            end
         endcase
      end
   end

   // Build the next table: count update, gap close, then append
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         id_in[i]  = id_ff[i];
         cnt_in[i] = cnt_ff[i];
      end
      if (update_en) begin
         cnt_in[pos] = update_val;
      end
      if (remove_en) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (IdxW'(i) >= remove_pos) begin
               id_in[i]  = id_ff[i+1];
               cnt_in[i] = cnt_ff[i+1];
            end
         end
      end
      if (append_en) begin
         id_in[append_idx]  = item_ff.id;
         cnt_in[append_idx] = CountW'(1);
      end
   end

   assign occ_wide = {5'b0, occ_in};

   // Sequence lookup and execute; hold state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOOKUP;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOOKUP: begin
               if (q_valid) begin
                  state_ff <= S_EXEC;
               end
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (out_free) begin
                  state_ff     <= S_LOOKUP;
                  occ_ff       <= occ_in;
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= hit;
                  rsp_cnt_ff   <= res_cnt;
                  rsp_occ_ff   <= occ_wide[4:0];
                  rsp_evict_ff <= res_evict;
               end
            end
            default: begin
               state_ff <= S_LOOKUP;
            end
         endcase
      end
   end

   // Load the held item and its match vector
   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff  <= q_item;
         match_ff <= match_in;
      end
   end

   // Advance the table entries
   always_ff @(posedge clock) begin
      if (do_exec) begin
         for (int i = 0; i < DEPTH; i++) begin
            id_ff[i]  <= id_in[i];
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_ref_count      = rsp_cnt_ff;
   assign rsp_entry_count    = rsp_occ_ff;
   assign rsp_evicted_oldest = rsp_evict_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OccFull) else $error("table fill exceeds depth");

   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> $onehot0(match_ff)) else $error("identifier matched twice");

   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evict_ff) |-> (!rsp_hit_ff && rsp_cnt_ff == CountW'(1)))
      else $error("eviction on a hit or with wrong count");

   a_pop_in_lookup: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == S_EXEC) else $error("popped item not executed");

endmodule

@@ hdl/refcounted_id_table.sv @@
// Reference-counted identifier table, top level. The table unit pops an item
// into its held-item register in the lookup step and updates the table and the
// result register in the execute step, one item at a time. The two-entry front
// queue keeps accepting while a result waits, until both entries are full.
// Reset clears the queue, the table fill and the result valid; entry contents
// are not cleared and no clearing pass runs. Instantiates rcit_front, rcit_back.
module refcounted_id_table #(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_operation,
   input  logic [31:0]  req_item_id,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_hit,
   output logic [15:0]  rsp_ref_count,
   output logic [4:0]   rsp_entry_count,
   output logic         rsp_evicted_oldest
);
   import rcit_pkg::*;

   logic      q_valid;
   logic      q_pop;
   item_type  q_item;

   // Accept and queue request beats
   rcit_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_item_id   (req_item_id),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   // Carry out table operations and deliver result beats
   rcit_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_ref_count      (rsp_ref_count),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_evicted_oldest (rsp_evicted_oldest)
   );

endmodule
